// ===== rtl/core/rule_overlap_dependency_finder_defines.svh =====
// ----------------------------------------------------------------------------
// rule_overlap_dependency_finder_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef RULE_OVERLAP_DEPENDENCY_FINDER_DEFINES_SVH
`define RULE_OVERLAP_DEPENDENCY_FINDER_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define ROFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is low.
`define ROFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rofd_pkg.sv =====
// ----------------------------------------------------------------------------
// rofd_pkg
// Types, codes and the range overlap function of the rule overlap finder.
// ----------------------------------------------------------------------------
`default_nettype none

package rofd_pkg;

    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int PRIO_W  = 16;
    localparam int INDEX_W = 7;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]   src_ip_lo;
        logic [IP_W-1:0]   src_ip_hi;
        logic [IP_W-1:0]   dst_ip_lo;
        logic [IP_W-1:0]   dst_ip_hi;
        logic [PORT_W-1:0] src_port_lo;
        logic [PORT_W-1:0] src_port_hi;
        logic [PORT_W-1:0] dst_port_lo;
        logic [PORT_W-1:0] dst_port_hi;
        logic [PRIO_W-1:0] prio;
    } t_rule;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic load;   // capture compare result against the query
        logic shift;  // take the neighbor's flag
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SCAN,
        ST_FLUSH
    } t_seq_state;

    // Stored range s meets query range q; inverted ranges follow the same test.
    function automatic logic ranges_meet(
        input logic [IP_W-1:0] s_lo,
        input logic [IP_W-1:0] s_hi,
        input logic [IP_W-1:0] q_lo,
        input logic [IP_W-1:0] q_hi
    );
        ranges_meet = ((s_lo <= q_lo) && (s_hi >= q_lo)) ||
                      ((s_lo > q_lo) && (s_lo <= q_hi));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rofd_cell.sv =====
// ----------------------------------------------------------------------------
// rofd_cell
// One table entry: holds a rule, compares it with the query and passes its
// match flag toward the head of the chain during the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module rofd_cell
    import rofd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_wr_en,
    input  wire t_rule     i_wr_rule,
    input  wire t_rule     i_query,
    input  wire logic      i_nb_flag,
    input  wire logic      i_nb_dir,
    output logic           o_flag,
    output logic           o_dir
);

    t_rule r_rule;
    logic  r_flag;
    logic  r_dir;
    logic  match;
    logic  dir_cmp;

    always_comb begin
        match = ranges_meet(r_rule.src_ip_lo, r_rule.src_ip_hi,
                            i_query.src_ip_lo, i_query.src_ip_hi) &&
                ranges_meet(r_rule.dst_ip_lo, r_rule.dst_ip_hi,
                            i_query.dst_ip_lo, i_query.dst_ip_hi) &&
                ranges_meet(IP_W'(r_rule.src_port_lo), IP_W'(r_rule.src_port_hi),
                            IP_W'(i_query.src_port_lo), IP_W'(i_query.src_port_hi)) &&
                ranges_meet(IP_W'(r_rule.dst_port_lo), IP_W'(r_rule.dst_port_hi),
                            IP_W'(i_query.dst_port_lo), IP_W'(i_query.dst_port_hi));
        dir_cmp = !(r_rule.prio < i_query.prio);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_rule <= i_wr_rule;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_flag <= match;
            r_dir  <= dir_cmp;
        end else if (i_ctl.shift) begin
            r_flag <= i_nb_flag;
            r_dir  <= i_nb_dir;
        end
    end

    assign o_flag = r_flag;
    assign o_dir  = r_dir;

endmodule

`default_nettype wire

// ===== rtl/core/rofd_seq.sv =====
// ----------------------------------------------------------------------------
// rofd_seq
// Query sequencer: loads the cell flags, pops one entry per cycle from the
// chain head when no output stall holds it, holds the latest hit back until
// the next one or the scan end decides its last mark; drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rofd_seq
    import rofd_pkg::*;
#(
    parameter int RULE_ENTRIES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [$clog2(RULE_ENTRIES+1)-1:0] i_limit,
    input  wire logic                 i_head_flag,
    input  wire logic                 i_head_dir,
    input  wire logic                 i_out_stall,
    output logic                      o_busy,
    output t_cell_ctl                 o_ctl,
    output logic                      o_out_valid,
    output logic                      o_hit,
    output logic [INDEX_W-1:0]        o_match_index,
    output logic                      o_direction,
    output logic                      o_last
);

    localparam int IDX_W = $clog2(RULE_ENTRIES + 1);

    t_seq_state         r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_limit, n_limit;
    logic               r_pend_v, n_pend_v;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic               r_pend_dir, n_pend_dir;
    logic               r_out_v, n_out_v;
    logic               r_out_hit, n_out_hit;
    logic [INDEX_W-1:0] r_out_idx, n_out_idx;
    logic               r_out_dir, n_out_dir;
    logic               r_out_last, n_out_last;
    logic               slot_free;

    assign slot_free = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_limit    <= n_limit;
        r_pend_idx <= n_pend_idx;
        r_pend_dir <= n_pend_dir;
        r_out_hit  <= n_out_hit;
        r_out_idx  <= n_out_idx;
        r_out_dir  <= n_out_dir;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_limit    = r_limit;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        n_pend_dir = r_pend_dir;
        n_out_v    = r_out_v && i_out_stall;
        n_out_hit  = r_out_hit;
        n_out_idx  = r_out_idx;
        n_out_dir  = r_out_dir;
        n_out_last = r_out_last;
        o_ctl      = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_limit  = i_limit;
                    n_pend_v = 1'b0;
                    n_state  = ST_CMP;
                end
            end
            ST_CMP: begin
                o_ctl.load = 1'b1;
                n_idx      = IDX_W'(1);
                n_state    = (r_limit == '0) ? ST_FLUSH : ST_SCAN;
            end
            ST_SCAN: begin
                // Hold the chain while a new hit would displace an unsent one.
                if (!(i_head_flag && r_pend_v) || slot_free) begin
                    o_ctl.shift = 1'b1;
                    if (i_head_flag) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_hit  = 1'b1;
                            n_out_idx  = INDEX_W'(r_pend_idx);
                            n_out_dir  = r_pend_dir;
                            n_out_last = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_idx = r_idx;
                        n_pend_dir = i_head_dir;
                    end
                    n_idx = r_idx + IDX_W'(1);
                    if (r_idx == r_limit) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_out_v    = 1'b1;
                    n_out_hit  = r_pend_v;
                    n_out_idx  = r_pend_v ? INDEX_W'(r_pend_idx) : '0;
                    n_out_dir  = r_pend_v && r_pend_dir;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_v;
    assign o_hit         = r_out_hit;
    assign o_match_index = r_out_idx;
    assign o_direction   = r_out_dir;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/rule_overlap_dependency_finder.sv =====
// ----------------------------------------------------------------------------
// rule_overlap_dependency_finder
// Rule table with overlap search: a chain of cells, one per entry, and a
// sequencer that reports overlapping entries in index order.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  in       | in        | i_in_valid / o_in_stall  | request type, index, rule
//  out      | out       | o_out_valid / i_out_stall| hit, match index, dir, last
//  cfg      | in        | i_cfg_valid / o_cfg_ready| active rule count
//
//  A write transaction is stored in the accepting cycle.
//  A query is registered, all cells compare against it, entries up to limit =
//  min(active rules, RULE_ENTRIES) are popped from the chain head in order,
//  and the final result is emitted.
//  A stalled output holds the scan when a second hit is waiting.
//  Synchronous active-low reset idles the sequencer and clears the count;
//  the table itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rule_overlap_dependency_finder
    import rofd_pkg::*;
#(
    parameter int RULE_ENTRIES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_req_type,
    input  wire logic [INDEX_W-1:0] i_rule_index,
    input  wire logic [IP_W-1:0]    i_src_ip_low,
    input  wire logic [IP_W-1:0]    i_src_ip_high,
    input  wire logic [IP_W-1:0]    i_dst_ip_low,
    input  wire logic [IP_W-1:0]    i_dst_ip_high,
    input  wire logic [PORT_W-1:0]  i_src_port_low,
    input  wire logic [PORT_W-1:0]  i_src_port_high,
    input  wire logic [PORT_W-1:0]  i_dst_port_low,
    input  wire logic [PORT_W-1:0]  i_dst_port_high,
    input  wire logic [PRIO_W-1:0]  i_rule_priority,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_hit,
    output logic [INDEX_W-1:0]      o_match_index,
    output logic                    o_direction,
    output logic                    o_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [INDEX_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(RULE_ENTRIES + 1);

    t_rule              in_rule;
    t_rule              r_query;
    logic [INDEX_W-1:0] r_active;
    logic               busy;
    logic               accept;
    logic               start;
    logic [IDX_W-1:0]   limit;
    t_cell_ctl          cell_ctl;
    logic [RULE_ENTRIES:0] flag_chain;
    logic [RULE_ENTRIES:0] dir_chain;

    assign in_rule = '{src_ip_lo:   i_src_ip_low,   src_ip_hi:   i_src_ip_high,
                       dst_ip_lo:   i_dst_ip_low,   dst_ip_hi:   i_dst_ip_high,
                       src_port_lo: i_src_port_low, src_port_hi: i_src_port_high,
                       dst_port_lo: i_dst_port_low, dst_port_hi: i_dst_port_high,
                       prio:        i_rule_priority};

    assign o_in_stall  = busy;
    assign accept      = i_in_valid && !busy;
    assign start       = accept && (i_req_type == REQ_QUERY);
    assign o_cfg_ready = 1'b1;

    assign limit = (r_active > INDEX_W'(RULE_ENTRIES)) ? IDX_W'(RULE_ENTRIES)
                                                       : r_active[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_valid) begin
            r_active <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_query <= in_rule;
        end
    end

    // Tail of the chain feeds empty flags.
    assign flag_chain[RULE_ENTRIES] = 1'b0;
    assign dir_chain[RULE_ENTRIES]  = 1'b0;

    for (genvar k = 0; k < RULE_ENTRIES; k++) begin : g_cell
        logic wr_en;
        assign wr_en = accept && (i_req_type == REQ_WRITE) &&
                       (i_rule_index == INDEX_W'(k + 1));
        rofd_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_wr_en   (wr_en),
            .i_wr_rule (in_rule),
            .i_query   (r_query),
            .i_nb_flag (flag_chain[k+1]),
            .i_nb_dir  (dir_chain[k+1]),
            .o_flag    (flag_chain[k]),
            .o_dir     (dir_chain[k])
        );
    end

    rofd_seq #(
        .RULE_ENTRIES (RULE_ENTRIES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_limit       (limit),
        .i_head_flag   (flag_chain[0]),
        .i_head_dir    (dir_chain[0]),
        .i_out_stall   (i_out_stall),
        .o_busy        (busy),
        .o_ctl         (cell_ctl),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_match_index (o_match_index),
        .o_direction   (o_direction),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rofd_checker.sv =====
// ----------------------------------------------------------------------------
// rofd_checker
// Port-level checks of the rule overlap finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rule_overlap_dependency_finder_defines.svh"

module rofd_checker
    import rofd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               i_req_type,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic               o_hit,
    input wire logic [INDEX_W-1:0] o_match_index,
    input wire logic               o_direction,
    input wire logic               o_last
);

    `ROFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `ROFD_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_req_type == REQ_QUERY), o_in_stall, "query did not block input")
    `ROFD_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_req_type == REQ_WRITE) && !o_out_valid, !o_out_valid, "write produced a result")
    `ROFD_ASSERT_NOW(a_miss_form, i_clk, i_rst_n, o_out_valid && !o_hit, o_last && (o_match_index == '0) && !o_direction, "malformed miss result")
    `ROFD_ASSERT_NOW(a_hit_index, i_clk, i_rst_n, o_out_valid && o_hit, o_match_index != '0, "hit with zero index")

endmodule

bind rule_overlap_dependency_finder rofd_checker u_rofd_checker (.*);

`default_nettype wire

// ===== tb/tb_rule_overlap_dependency_finder.sv =====
// ----------------------------------------------------------------------------
// tb_rule_overlap_dependency_finder
// Self-checking bench for the rule overlap finder. A short table of directed
// rows covers reset state, range extremes, inverted ranges and ignored write
// indexes. Random rule writes and overlap queries follow under several active
// rule counts, some clamped. Queries are scored against a fixed verdict or a
// local model of the rule table. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rule_overlap_dependency_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import rofd_pkg::*;

    localparam int RULE_ENTRIES  = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic DIR_LOWER       = 1'b0;
    localparam logic DIR_AT_OR_ABOVE = 1'b1;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] match_index;
        logic               direction;
        logic               last;
    } t_verdict;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [INDEX_W-1:0] cfg_val;
        logic               req_type;
        logic [INDEX_W-1:0] index;
        t_rule              rule;
        bit                 typed;
        t_verdict           want;
    } t_row;

    localparam t_verdict MISS_RESULT = '{1'b0, 7'd0, DIR_LOWER, 1'b1};
    localparam t_verdict NO_RESULT   = '0;

    localparam t_rule FULL_SPAN  = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                     16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h8000};
    localparam t_rule ZERO_POINT = '0;
    localparam t_rule TOP_POINT  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 16'hFFFF};
    localparam t_rule NARROW     = '{32'd100, 32'd200, 32'd1000, 32'd2000,
                                     16'd10, 16'd20, 16'd80, 16'd443, 16'h0};
    localparam t_rule INVERTED   = '{32'd500, 32'd300, 32'hFFFF_0000, 32'h0000_FFFF,
                                     16'd9000, 16'd8000, 16'hFFFE, 16'h0001, 16'hFFFF};
    localparam t_rule PROBE      = '{32'd150, 32'd150, 32'd1500, 32'd1500,
                                     16'd15, 16'd15, 16'd100, 16'd100, 16'd1};

    logic               i_clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               req_type   = REQ_WRITE;
    logic [INDEX_W-1:0] rule_index = '0;
    t_rule              in_rule    = '0;
    logic               out_stall  = 1'b0;
    logic               cfg_valid  = 1'b0;
    logic [INDEX_W-1:0] cfg_data   = '0;

    wire                o_in_stall;
    wire                o_out_valid;
    wire                o_hit;
    wire [INDEX_W-1:0]  o_match_index;
    wire                o_direction;
    wire                o_last;
    wire                o_cfg_ready;

    t_verdict    expected_overlaps[$];
    t_rule       rule_copy[RULE_ENTRIES];
    int          active_cnt = 0;
    int          idle_pct   = 35;
    int          fail_cnt   = 0;
    int          cycle_cnt  = 0;
    int unsigned active_steps[$] = '{64, 127, 1, 0, 42, 85, 64};

    rule_overlap_dependency_finder #(
        .RULE_ENTRIES(RULE_ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (req_type),
        .i_rule_index   (rule_index),
        .i_src_ip_low   (in_rule.src_ip_lo),
        .i_src_ip_high  (in_rule.src_ip_hi),
        .i_dst_ip_low   (in_rule.dst_ip_lo),
        .i_dst_ip_high  (in_rule.dst_ip_hi),
        .i_src_port_low (in_rule.src_port_lo),
        .i_src_port_high(in_rule.src_port_hi),
        .i_dst_port_low (in_rule.dst_port_lo),
        .i_dst_port_high(in_rule.dst_port_hi),
        .i_rule_priority(in_rule.prio),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_hit          (o_hit),
        .o_match_index  (o_match_index),
        .o_direction    (o_direction),
        .o_last         (o_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** rule_overlap_dependency_finder: FAILED **");
            $finish;
        end
    end

    // Stored range reaches the query's low end, or starts inside the query.
    function automatic bit spans_touch(input logic [31:0] s_lo, input logic [31:0] s_hi,
                                       input logic [31:0] q_lo, input logic [31:0] q_hi);
        if (s_lo <= q_lo)
            return s_hi >= q_lo;
        return s_lo <= q_hi;
    endfunction

    task automatic predict_overlaps(input t_rule q);
        t_rule    s;
        t_verdict v;
        bit       touch[RULE_ENTRIES];
        int       last_hit;
        last_hit = 0;
        for (int e = 1; e <= active_cnt; e++) begin
            s = rule_copy[e-1];
            touch[e-1] = spans_touch(s.src_ip_lo, s.src_ip_hi, q.src_ip_lo, q.src_ip_hi) &&
                         spans_touch(s.dst_ip_lo, s.dst_ip_hi, q.dst_ip_lo, q.dst_ip_hi) &&
                         spans_touch(32'(s.src_port_lo), 32'(s.src_port_hi),
                                     32'(q.src_port_lo), 32'(q.src_port_hi)) &&
                         spans_touch(32'(s.dst_port_lo), 32'(s.dst_port_hi),
                                     32'(q.dst_port_lo), 32'(q.dst_port_hi));
            if (touch[e-1])
                last_hit = e;
        end
        if (last_hit == 0) begin
            expected_overlaps = {expected_overlaps, MISS_RESULT};
        end else begin
            for (int e = 1; e <= last_hit; e++) begin
                if (touch[e-1]) begin
                    v.hit         = 1'b1;
                    v.match_index = e[INDEX_W-1:0];
                    v.direction   = (rule_copy[e-1].prio < q.prio) ? DIR_LOWER
                                                                   : DIR_AT_OR_ABOVE;
                    v.last        = (e == last_hit);
                    expected_overlaps = {expected_overlaps, v};
                end
            end
        end
    endtask

    function automatic logic [31:0] pick_bound(input logic [31:0] top);
        case ($urandom_range(0, 4))
            0:       return $urandom & top;
            1:       return $urandom_range(0, 4095);
            2:       return top - $urandom_range(0, 4095);
            3:       return '0;
            default: return top;
        endcase
    endfunction

    // Upper bound may wrap below the lower one: inverted ranges are legal.
    function automatic logic [31:0] pick_upper(input logic [31:0] lo, input logic [31:0] top);
        case ($urandom_range(0, 3))
            0:       return (lo + $urandom_range(0, 2000)) & top;
            1:       return $urandom & top;
            2:       return lo;
            default: return top;
        endcase
    endfunction

    function automatic t_rule rand_rule();
        t_rule r;
        r.src_ip_lo   = pick_bound(32'hFFFF_FFFF);
        r.src_ip_hi   = pick_upper(r.src_ip_lo, 32'hFFFF_FFFF);
        r.dst_ip_lo   = pick_bound(32'hFFFF_FFFF);
        r.dst_ip_hi   = pick_upper(r.dst_ip_lo, 32'hFFFF_FFFF);
        r.src_port_lo = 16'(pick_bound(32'hFFFF));
        r.src_port_hi = 16'(pick_upper(32'(r.src_port_lo), 32'hFFFF));
        r.dst_port_lo = 16'(pick_bound(32'hFFFF));
        r.dst_port_hi = 16'(pick_upper(32'(r.dst_port_lo), 32'hFFFF));
        case ($urandom_range(0, 3))
            0:       r.prio = 16'($urandom);
            1:       r.prio = 16'h0;
            2:       r.prio = 16'hFFFF;
            default: r.prio = 16'($urandom_range(16'h7FFE, 16'h8001));
        endcase
        return r;
    endfunction

    task automatic issue(input logic kind, input logic [INDEX_W-1:0] idx, input t_rule r,
                         input bit typed, input t_verdict want);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        rule_index <= idx;
        in_rule    <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (typed)
            expected_overlaps = {expected_overlaps, want};
        else if (kind == REQ_QUERY)
            predict_overlaps(r);
        if (kind == REQ_WRITE && idx >= 1 && idx <= RULE_ENTRIES)
            rule_copy[idx-1] = r;
    endtask

    // Count changes only with the table idle: drain, then let the sequencer settle.
    task automatic set_active(input logic [INDEX_W-1:0] n);
        in_valid <= 1'b0;
        while (expected_overlaps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid  <= 1'b0;
        active_cnt = (n > RULE_ENTRIES) ? RULE_ENTRIES : n;
    endtask

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_overlaps.size() == 0) begin
                $error("result with nothing pending: hit %0d index %0d", o_hit,
                       o_match_index);
                fail_cnt++;
            end else begin
                want = expected_overlaps.pop_front();
                check_field("hit", want.hit, o_hit);
                check_field("match_index", want.match_index, o_match_index);
                check_field("direction", want.direction, o_direction);
                check_field("last", want.last, o_last);
            end
        end
    end

    initial begin
        t_row               plan[$];
        logic [INDEX_W-1:0] idx;

        plan = '{
            // reset count is zero: every query misses
            '{ROW_ITEM, 7'd0, REQ_QUERY, 7'h7F, FULL_SPAN,  1'b1, MISS_RESULT},
            // out-of-range write indexes are dropped
            '{ROW_ITEM, 7'd0, REQ_WRITE, 7'd0,   FULL_SPAN,  1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_WRITE, 7'd65,  ZERO_POINT, 1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_WRITE, 7'd127, TOP_POINT,  1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_WRITE, 7'd1,   FULL_SPAN,  1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_WRITE, 7'd2,   NARROW,     1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_WRITE, 7'd3,   INVERTED,   1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_WRITE, 7'd4,   TOP_POINT,  1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_QUERY, 7'd0,   NARROW,     1'b1, MISS_RESULT},
            '{ROW_CFG,  7'd4, REQ_WRITE, 7'd0,   ZERO_POINT, 1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_QUERY, 7'd0,   FULL_SPAN,  1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_QUERY, 7'd1,   ZERO_POINT, 1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_QUERY, 7'd64,  TOP_POINT,  1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_QUERY, 7'd3,   INVERTED,   1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_QUERY, 7'h55,  PROBE,      1'b0, NO_RESULT},
            '{ROW_ITEM, 7'd0, REQ_QUERY, 7'h2A,  NARROW,     1'b0, NO_RESULT}
        };
        active_steps = {active_steps, $urandom_range(1, 127)};

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG)
                set_active(plan[n].cfg_val);
            else
                issue(plan[n].req_type, plan[n].index, plan[n].rule, plan[n].typed,
                      plan[n].want);
        end

        // fill every entry before any count can reach it
        for (int e = 1; e <= RULE_ENTRIES; e++) begin
            issue(REQ_WRITE, e[INDEX_W-1:0], rand_rule(), 1'b0, NO_RESULT);
            if ($urandom_range(0, 3) == 0)
                issue(REQ_QUERY, 7'($urandom_range(0, 127)), rand_rule(), 1'b0, NO_RESULT);
        end

        foreach (active_steps[p]) begin
            set_active(active_steps[p][INDEX_W-1:0]);
            idle_pct = (p == 1) ? 0 : 35;
            repeat (20) begin
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 9) == 0)
                        idx = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
                    else
                        idx = 7'($urandom_range(1, RULE_ENTRIES));
                    issue(REQ_WRITE, idx, rand_rule(), 1'b0, NO_RESULT);
                end else begin
                    issue(REQ_QUERY, 7'($urandom_range(0, 127)), rand_rule(), 1'b0,
                          NO_RESULT);
                end
            end
        end

        in_valid <= 1'b0;
        while (expected_overlaps.size() != 0) @(posedge i_clk);
        repeat (RULE_ENTRIES + SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("** rule_overlap_dependency_finder: PASSED **");
        else
            $display("** rule_overlap_dependency_finder: FAILED **");
        $finish;
    end

endmodule
